FILE: rtl/mdio45_pkg.sv
// Shared types and constants for the MDIO clause 45 frame slave.
// Used by mdio45_step and mdio_clause45_frame_slave; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package mdio45_pkg;

   localparam int unsigned CsrDataWidth  = 6;
   localparam int unsigned CsrIndexWidth = 2;

   // Configuration register indexes.
   localparam logic [CsrIndexWidth-1:0] CSR_PORT_ADDRESS   = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_DEVICE_TYPE    = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_DEVICE_PRESENT = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_MIN_PREAMBLE   = 2'd3;

   localparam logic [5:0] MIN_PREAMBLE_RESET = 6'd16;
   localparam logic [5:0] PREAMBLE_MAX       = 6'd63;
   localparam logic [5:0] ADDR_FIELD_BITS    = 6'd5;
   localparam logic [5:0] DATA_FIELD_BITS    = 6'd16;
   localparam logic [5:0] SKIP_BITS          = 6'd18;

   // Frame opcodes.
   localparam logic [1:0] OPC_ADDRESS = 2'b00;
   localparam logic [1:0] OPC_WRITE   = 2'b01;
   localparam logic [1:0] OPC_READINC = 2'b10;
   localparam logic [1:0] OPC_READ    = 2'b11;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_ST    = 4'd1,
      PH_OP1   = 4'd2,
      PH_OP2   = 4'd3,
      PH_TA1   = 4'd4,
      PH_TA2   = 4'd5,
      PH_PORT  = 4'd6,
      PH_TYPE  = 4'd7,
      PH_READ  = 4'd8,
      PH_WRITE = 4'd9,
      PH_SKIP  = 4'd10
   } phase_type;

   typedef enum logic [1:0] {
      PIN_OPEN = 2'd0,
      PIN_LOW  = 2'd1,
      PIN_HIGH = 2'd2
   } pin_type;

   typedef struct packed {
      logic        mdio_in;
      logic [15:0] read_data;
   } req_type;

   typedef struct packed {
      logic [1:0]  mdio_drive;
      logic        read_request;
      logic        read_increment;
      logic        address_strobe;
      logic        write_strobe;
      logic [15:0] frame_data;
      logic        frame_error;
   } rsp_type;

   typedef struct packed {
      logic [4:0] port_address;
      logic [4:0] device_type;
      logic       device_present;
      logic [5:0] min_preamble;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic [5:0]  bit_counter;
      logic [1:0]  opcode;
      logic [4:0]  port_shift;
      logic [4:0]  type_shift;
      logic [15:0] data_shift;
      pin_type     pin_state;
   } frame_state_type;

endpackage

`default_nettype wire

FILE: rtl/mdio45_step.sv
// Frame walker for one sampled MDIO bit: next frame state and the result.
// Purely combinational; depends on mdio45_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mdio45_step (
   input  mdio45_pkg::frame_state_type cur,
   input  mdio45_pkg::cfg_type         cfg,
   input  mdio45_pkg::req_type         req,
   output mdio45_pkg::frame_state_type nxt,
   output mdio45_pkg::rsp_type         rsp
);

   logic       wr_like;
   logic [5:0] cnt_inc;

   assign wr_like = (cur.opcode == mdio45_pkg::OPC_WRITE) ||
                    (cur.opcode == mdio45_pkg::OPC_ADDRESS);
   assign cnt_inc = cur.bit_counter + 6'd1;

   always_comb begin
      nxt = cur;
      rsp = '0;
      unique case (cur.phase)
         mdio45_pkg::PH_IDLE: begin
            if (!req.mdio_in) begin
               if (cur.bit_counter >= cfg.min_preamble) begin
                  nxt.phase = mdio45_pkg::PH_ST;
               end else begin
                  nxt.bit_counter = '0;
               end
            end else if (cur.bit_counter != mdio45_pkg::PREAMBLE_MAX) begin
               nxt.bit_counter = cnt_inc;
            end
         end
         mdio45_pkg::PH_ST: begin
            if (!req.mdio_in) begin
               nxt.phase = mdio45_pkg::PH_OP1;
            end else begin
               nxt.phase       = mdio45_pkg::PH_IDLE;
               nxt.bit_counter = '0;
            end
         end
         mdio45_pkg::PH_OP1: begin
            nxt.opcode = {req.mdio_in, 1'b0};
            nxt.phase  = mdio45_pkg::PH_OP2;
         end
         mdio45_pkg::PH_OP2: begin
            nxt.opcode      = {cur.opcode[1], req.mdio_in};
            nxt.port_shift  = '0;
            nxt.bit_counter = '0;
            nxt.phase       = mdio45_pkg::PH_PORT;
         end
         mdio45_pkg::PH_PORT: begin
            nxt.port_shift  = {cur.port_shift[3:0], req.mdio_in};
            nxt.bit_counter = cnt_inc;
            if (cnt_inc >= mdio45_pkg::ADDR_FIELD_BITS) begin
               nxt.bit_counter = '0;
               nxt.type_shift  = '0;
               nxt.phase       = mdio45_pkg::PH_TYPE;
            end
         end
         mdio45_pkg::PH_TYPE: begin
            nxt.type_shift  = {cur.type_shift[3:0], req.mdio_in};
            nxt.bit_counter = cnt_inc;
            if (cnt_inc >= mdio45_pkg::ADDR_FIELD_BITS) begin
               nxt.bit_counter = '0;
               if (cfg.device_present && (cur.port_shift == cfg.port_address) &&
                   ({cur.type_shift[3:0], req.mdio_in} == cfg.device_type)) begin
                  nxt.phase = mdio45_pkg::PH_TA1;
               end else begin
                  nxt.phase = mdio45_pkg::PH_SKIP;
               end
            end
         end
         mdio45_pkg::PH_TA1: begin
            if (wr_like) begin
               if (!req.mdio_in) begin
                  rsp.frame_error = 1'b1;
                  nxt.phase       = mdio45_pkg::PH_IDLE;
                  nxt.bit_counter = '0;
               end else begin
                  nxt.phase = mdio45_pkg::PH_TA2;
               end
            end else begin
               nxt.pin_state = mdio45_pkg::PIN_LOW;
               nxt.phase     = mdio45_pkg::PH_TA2;
            end
         end
         mdio45_pkg::PH_TA2: begin
            if (wr_like) begin
               if (req.mdio_in) begin
                  rsp.frame_error = 1'b1;
                  nxt.phase       = mdio45_pkg::PH_IDLE;
                  nxt.bit_counter = '0;
               end else begin
                  nxt.bit_counter = '0;
                  nxt.phase       = mdio45_pkg::PH_WRITE;
               end
            end else begin
               // Take the register value and drive its MSB on this same edge.
               rsp.read_request   = 1'b1;
               rsp.read_increment = (cur.opcode == mdio45_pkg::OPC_READINC);
               nxt.pin_state      = req.read_data[15] ? mdio45_pkg::PIN_HIGH
                                                      : mdio45_pkg::PIN_LOW;
               nxt.data_shift     = {req.read_data[14:0], 1'b0};
               nxt.bit_counter    = 6'd1;
               nxt.phase          = mdio45_pkg::PH_READ;
            end
         end
         mdio45_pkg::PH_READ: begin
            if (cur.bit_counter >= mdio45_pkg::DATA_FIELD_BITS) begin
               nxt.pin_state   = mdio45_pkg::PIN_OPEN;
               nxt.phase       = mdio45_pkg::PH_IDLE;
               nxt.bit_counter = '0;
            end else begin
               nxt.pin_state   = cur.data_shift[15] ? mdio45_pkg::PIN_HIGH
                                                    : mdio45_pkg::PIN_LOW;
               nxt.data_shift  = {cur.data_shift[14:0], 1'b0};
               nxt.bit_counter = cnt_inc;
            end
         end
         mdio45_pkg::PH_WRITE: begin
            nxt.data_shift  = {cur.data_shift[14:0], req.mdio_in};
            nxt.bit_counter = cnt_inc;
            if (cnt_inc >= mdio45_pkg::DATA_FIELD_BITS) begin
               if (cur.opcode == mdio45_pkg::OPC_ADDRESS) begin
                  rsp.address_strobe = 1'b1;
               end else begin
                  rsp.write_strobe = 1'b1;
               end
               rsp.frame_data  = {cur.data_shift[14:0], req.mdio_in};
               nxt.phase       = mdio45_pkg::PH_IDLE;
               nxt.bit_counter = '0;
            end
         end
         mdio45_pkg::PH_SKIP: begin
            nxt.bit_counter = cnt_inc;
            if (cnt_inc >= mdio45_pkg::SKIP_BITS) begin
               nxt.phase       = mdio45_pkg::PH_IDLE;
               nxt.bit_counter = '0;
            end
         end
         default: begin
            nxt.pin_state   = mdio45_pkg::PIN_OPEN;
            nxt.phase       = mdio45_pkg::PH_IDLE;
            nxt.bit_counter = '0;
         end
      endcase
      rsp.mdio_drive = nxt.pin_state;
   end

endmodule

`default_nettype wire

FILE: rtl/mdio_clause45_frame_slave.sv
// Top level of the MDIO clause 45 frame slave: frame state, configuration
// registers and the result register. Depends on mdio45_pkg and mdio45_step.
`timescale 1ns / 1ps
`default_nettype none

// Each request carries one MDIO level sampled at an MDC rising edge (and the
// register value for reads); each request yields exactly one response with
// the pin drive after that edge and the frame strobes. The block takes one
// request per clock: the whole frame step is a single level of logic from the
// frame state registers to the response register, so a response appears in the
// cycle after its request is accepted, and a new request is taken whenever the
// response register is empty or is being drained in the same cycle.
// Configuration is a plain write port; write it only while no frame is active.
module mdio_clause45_frame_slave (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     req_valid,
   output logic                                    req_ready,
   input  mdio45_pkg::req_type                     req_data,
   output logic                                    rsp_valid,
   input  wire                                     rsp_ready,
   output mdio45_pkg::rsp_type                     rsp_data,
   input  wire                                     csr_wr_en,
   input  wire  [mdio45_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire  [mdio45_pkg::CsrDataWidth-1:0]     csr_wdata
);

   mdio45_pkg::frame_state_type state_ff, state_in;
   mdio45_pkg::cfg_type         cfg_ff;
   mdio45_pkg::rsp_type         rsp_ff, rsp_in;
   logic                        rsp_valid_ff;
   logic                        req_fire;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   mdio45_step u_step (
      .cur (state_ff),
      .cfg (cfg_ff),
      .req (req_data),
      .nxt (state_in),
      .rsp (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase:      mdio45_pkg::PH_IDLE,
                       pin_state:  mdio45_pkg::PIN_OPEN,
                       default:    '0};
      end else if (req_fire) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.port_address   <= '0;
         cfg_ff.device_type    <= '0;
         cfg_ff.device_present <= 1'b0;
         cfg_ff.min_preamble   <= mdio45_pkg::MIN_PREAMBLE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            mdio45_pkg::CSR_PORT_ADDRESS:   cfg_ff.port_address   <= csr_wdata[4:0];
            mdio45_pkg::CSR_DEVICE_TYPE:    cfg_ff.device_type    <= csr_wdata[4:0];
            mdio45_pkg::CSR_DEVICE_PRESENT: cfg_ff.device_present <= csr_wdata[0];
            mdio45_pkg::CSR_MIN_PREAMBLE:   cfg_ff.min_preamble   <= csr_wdata[5:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   // A read request always comes with the first data bit on the pin.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.read_request |-> rsp_ff.mdio_drive != mdio45_pkg::PIN_OPEN)
      else $error("read request without an active pin drive");

   // Only one kind of frame event is reported per response.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_ff.read_request, rsp_ff.address_strobe,
                                 rsp_ff.write_strobe, rsp_ff.frame_error}))
      else $error("more than one frame event in one response");

   // Frame data is zero unless a write or address frame completes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.address_strobe && !rsp_ff.write_strobe
      |-> rsp_ff.frame_data == '0)
      else $error("frame data without a strobe");

   // While shifting read data the bit count stays within the data field.
   assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == mdio45_pkg::PH_READ
      |-> state_ff.bit_counter != '0 &&
          state_ff.bit_counter <= mdio45_pkg::DATA_FIELD_BITS)
      else $error("read bit count out of range");
`endif

endmodule

`default_nettype wire
